// ===== rtl/sumd_pkg.sv =====
// Shared types, codes and the CRC-16 step for the SUMD/SUMH frame decoder.
// Used by every module of the decoder; depends on nothing.
package sumd_pkg;

  localparam int MAX_CHANNELS = 32;
  localparam int STORE_BYTES  = 2 * MAX_CHANNELS;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [7:0]  HDR_BYTE    = 8'hA8;
  localparam logic [7:0]  ID_NORMAL   = 8'h01;
  localparam logic [7:0]  ID_FAILSAFE = 8'h81;
  localparam logic [7:0]  ID_ALT      = 8'h00;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [6:0]  SIG_FULL    = 7'd100;

  // result status codes
  localparam logic [1:0] ST_PROG = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_GOOD = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  // one job per accepted byte, handed from parser to emitter
  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] cnt;
    logic       fs;
    logic [7:0] fc;
  } job_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  idx;
    logic [12:0] val;
    logic [5:0]  cnt;
    logic        fs;
    logic [7:0]  fc;
    logic [6:0]  ss;
    logic        last;
  } result_t;

  // payload store write port, driven by the parser
  typedef struct packed {
    logic       clr;
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } store_wr_t;

  typedef struct packed {
    logic frame_done;
  } back_stat_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/sumd_front.sv =====
// Byte parser: sync, header checks, CRC/sum, payload writes and one job per byte.
// Depends on sumd_pkg.
module sumd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [7:0]           in_rx_byte,
  output logic                 in_full,
  input  logic                 cfg_valid,
  input  logic [5:0]           cfg_max_channels,
  input  logic                 jq_full,
  output logic                 jq_push,
  output sumd_pkg::job_t       jq_data,
  output sumd_pkg::store_wr_t  st_wr,
  input  sumd_pkg::back_stat_t bk_stat
);

  localparam logic [2:0] PS_UNSYNCED = 3'd0;
  localparam logic [2:0] PS_HEADER   = 3'd1;
  localparam logic [2:0] PS_STATUS   = 3'd2;
  localparam logic [2:0] PS_DATA     = 3'd3;
  localparam logic [2:0] PS_CHECK1   = 3'd4;
  localparam logic [2:0] PS_CHECK2   = 3'd5;
  localparam logic [2:0] PS_SKIP1    = 3'd6;
  localparam logic [2:0] PS_TELEM    = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic        sumd_r, sumd_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [7:0]  stat_r, stat_nxt;
  logic [7:0]  chk_hi_r, chk_hi_nxt;
  logic [7:0]  fcnt_r, fcnt_nxt;
  logic        pend_r, pend_nxt;
  logic [5:0]  maxch_r;

  logic        acc;
  logic        ok;
  logic        mode;
  logic [5:0]  lim;
  logic [5:0]  cnt;
  logic [7:0]  b;

  assign b = in_rx_byte;

  // hold off a new frame while the previous good one is still being emitted
  assign in_full = jq_full || (state_r == PS_UNSYNCED && pend_r);
  assign acc     = in_push && !in_full;

  assign lim = (maxch_r > 6'(sumd_pkg::MAX_CHANNELS)) ? 6'(sumd_pkg::MAX_CHANNELS) : maxch_r;
  assign cnt = (len_r > lim) ? lim : len_r;
  assign ok  = sumd_r ? (crc_r == {chk_hi_r, b}) : (sum_r == b);

  always_comb begin
    state_nxt  = state_r;
    sumd_nxt   = sumd_r;
    crc_nxt    = crc_r;
    sum_nxt    = sum_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    stat_nxt   = stat_r;
    chk_hi_nxt = chk_hi_r;
    fcnt_nxt   = fcnt_r;
    pend_nxt   = pend_r && !bk_stat.frame_done;
    mode       = sumd_r;
    st_wr      = '0;
    st_wr.data = b;
    st_wr.addr = 6'(idx_r - 7'd1);
    jq_push    = acc;
    jq_data    = '{kind: sumd_pkg::ST_PROG, cnt: 6'd0, fs: 1'b0, fc: fcnt_r};
    if (acc) begin
      case (state_r)
        PS_UNSYNCED: begin
          if (b != sumd_pkg::HDR_BYTE) begin
            jq_data.kind = sumd_pkg::ST_DROP;
          end else begin
            sumd_nxt  = 1'b1;
            idx_nxt   = 7'd0;
            st_wr.clr = 1'b1;
            crc_nxt   = sumd_pkg::crc_step(16'h0000, b);
            sum_nxt   = b;
            state_nxt = PS_HEADER;
          end
        end
        PS_HEADER: begin
          if (b == sumd_pkg::ID_NORMAL || b == sumd_pkg::ID_FAILSAFE ||
              b == sumd_pkg::ID_ALT) begin
            stat_nxt = b;
            if (b == sumd_pkg::ID_ALT) mode = 1'b0;
            sumd_nxt = mode;
            if (mode) crc_nxt = sumd_pkg::crc_step(crc_r, b);
            else      sum_nxt = sum_r + b;
            state_nxt = PS_STATUS;
          end else begin
            state_nxt = PS_UNSYNCED;
          end
        end
        PS_STATUS: begin
          if (b >= 8'd2 && b <= 8'(sumd_pkg::MAX_CHANNELS)) begin
            len_nxt = b[5:0];
            if (sumd_r) crc_nxt = sumd_pkg::crc_step(crc_r, b);
            else        sum_nxt = sum_r + b;
            idx_nxt   = 7'd1;
            state_nxt = PS_DATA;
          end else begin
            state_nxt = PS_UNSYNCED;
          end
        end
        PS_DATA: begin
          st_wr.en = 1'b1;
          if (sumd_r) crc_nxt = sumd_pkg::crc_step(crc_r, b);
          else        sum_nxt = sum_r + b;
          idx_nxt = idx_r + 7'd1;
          if ((idx_r + 7'd1) > {len_r, 1'b0}) state_nxt = PS_CHECK1;
        end
        PS_CHECK1: begin
          chk_hi_nxt = b;
          state_nxt  = sumd_r ? PS_CHECK2 : PS_SKIP1;
        end
        PS_SKIP1: state_nxt = PS_TELEM;
        PS_TELEM: state_nxt = PS_CHECK2;
        PS_CHECK2: begin
          state_nxt = PS_UNSYNCED;
          if (!ok) begin
            jq_data.kind = sumd_pkg::ST_BAD;
          end else begin
            fcnt_nxt     = fcnt_r + 8'd1;
            pend_nxt     = 1'b1;
            jq_data.kind = sumd_pkg::ST_GOOD;
            jq_data.cnt  = cnt;
            jq_data.fs   = (stat_r == sumd_pkg::ID_FAILSAFE);
            jq_data.fc   = fcnt_r + 8'd1;
          end
        end
        default: state_nxt = PS_UNSYNCED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= PS_UNSYNCED;
      sumd_r   <= 1'b1;
      crc_r    <= '0;
      sum_r    <= '0;
      idx_r    <= '0;
      len_r    <= '0;
      stat_r   <= '0;
      chk_hi_r <= '0;
      fcnt_r   <= '0;
      pend_r   <= 1'b0;
      maxch_r  <= 6'd32;
    end else begin
      state_r  <= state_nxt;
      sumd_r   <= sumd_nxt;
      crc_r    <= crc_nxt;
      sum_r    <= sum_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      stat_r   <= stat_nxt;
      chk_hi_r <= chk_hi_nxt;
      fcnt_r   <= fcnt_nxt;
      pend_r   <= pend_nxt;
      if (cfg_valid) maxch_r <= cfg_max_channels;
    end
  end

  a_no_sync_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && state_r == PS_UNSYNCED) |-> !pend_r)
    else $error("byte taken in unsynced state while a frame is still being emitted");

  a_good_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && state_r == PS_CHECK2 && ok) |=> pend_r)
    else $error("good frame did not mark emission pending");

  a_data_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PS_DATA) |-> (idx_r >= 7'd1 && idx_r <= 7'(sumd_pkg::STORE_BYTES)))
    else $error("payload index out of store range");

endmodule

// ===== rtl/sumd_jobq.sv =====
// Short job queue between the byte parser and the result emitter.
// Depends on sumd_pkg.
module sumd_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sumd_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output sumd_pkg::job_t rdata,
  output logic           empty
);

  localparam int AW = $clog2(sumd_pkg::QUEUE_DEPTH);

  sumd_pkg::job_t mem_r [sumd_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(sumd_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/sumd_back.sv =====
// Result emitter: payload store, channel reorder and the output result queue.
// Depends on sumd_pkg.
module sumd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sumd_pkg::store_wr_t  st_wr,
  input  logic                 jq_empty,
  input  sumd_pkg::job_t       jq_data,
  output logic                 jq_pop,
  output sumd_pkg::back_stat_t bk_stat,
  input  logic                 out_pop,
  output logic                 out_empty,
  output sumd_pkg::result_t    out_res
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_PUSH = 2'd2;

  localparam int WORDS = sumd_pkg::MAX_CHANNELS;
  localparam int QAW   = $clog2(sumd_pkg::QUEUE_DEPTH);

  // payload store, split into high and low byte of each channel word
  logic [7:0]       mem_hi [WORDS];
  logic [7:0]       mem_lo [WORDS];
  logic [WORDS-1:0] vld_hi_r, vld_lo_r;
  logic [7:0]       rd_hi_r, rd_lo_r;
  logic             rdv_hi_r, rdv_lo_r;

  logic [1:0]     bst_r, bst_nxt;
  sumd_pkg::job_t job_r, job_nxt;
  logic [4:0]     k_r, k_nxt;
  logic           single_r, single_nxt;
  logic [4:0]     src;
  logic [15:0]    word;
  logic           is_last;

  sumd_pkg::result_t res;
  sumd_pkg::result_t oq_r [sumd_pkg::QUEUE_DEPTH];
  logic [QAW-1:0]    owp_r, orp_r;
  logic [QAW:0]      ocnt_r;
  logic              o_full, o_push, o_pop;

  always_ff @(posedge clk) begin
    if (st_wr.en && !st_wr.addr[0]) mem_hi[st_wr.addr[5:1]] <= st_wr.data;
    if (st_wr.en &&  st_wr.addr[0]) mem_lo[st_wr.addr[5:1]] <= st_wr.data;
    rd_hi_r <= mem_hi[src];
    rd_lo_r <= mem_lo[src];
  end

  // valid bits stand in for clearing the store at each header
  always_ff @(posedge clk) begin
    if (!rst_n || st_wr.clr) begin
      vld_hi_r <= '0;
      vld_lo_r <= '0;
    end else if (st_wr.en) begin
      if (!st_wr.addr[0]) vld_hi_r[st_wr.addr[5:1]] <= 1'b1;
      else                vld_lo_r[st_wr.addr[5:1]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdv_hi_r <= vld_hi_r[src];
    rdv_lo_r <= vld_lo_r[src];
  end

  // first four outputs take source channels 1,2,0,3
  always_comb begin
    case (k_r)
      5'd0:    src = 5'd1;
      5'd1:    src = 5'd2;
      5'd2:    src = 5'd0;
      5'd3:    src = 5'd3;
      default: src = k_r;
    endcase
  end

  assign word    = {rdv_hi_r ? rd_hi_r : 8'h00, rdv_lo_r ? rd_lo_r : 8'h00};
  assign is_last = single_r || ((6'(k_r) + 6'd1) == job_r.cnt);
  assign o_full  = (ocnt_r == (QAW+1)'(sumd_pkg::QUEUE_DEPTH));
  assign o_push  = (bst_r == B_PUSH) && !o_full;
  assign jq_pop  = (bst_r == B_IDLE) && !jq_empty;
  assign bk_stat.frame_done = o_push && is_last && (job_r.kind == sumd_pkg::ST_GOOD);

  always_comb begin
    res        = '0;
    res.status = job_r.kind;
    res.fc     = job_r.fc;
    res.last   = is_last;
    if (job_r.kind == sumd_pkg::ST_GOOD) begin
      res.fs = job_r.fs;
      res.ss = sumd_pkg::SIG_FULL;
      if (!single_r) begin
        res.idx = k_r;
        res.val = word[15:3];
        res.cnt = job_r.cnt;
      end
    end
  end

  always_comb begin
    bst_nxt    = bst_r;
    job_nxt    = job_r;
    k_nxt      = k_r;
    single_nxt = single_r;
    case (bst_r)
      B_IDLE: begin
        if (!jq_empty) begin
          job_nxt    = jq_data;
          k_nxt      = 5'd0;
          single_nxt = (jq_data.kind != sumd_pkg::ST_GOOD) || (jq_data.cnt == 6'd0);
          bst_nxt    = ((jq_data.kind != sumd_pkg::ST_GOOD) || (jq_data.cnt == 6'd0))
                       ? B_PUSH : B_READ;
        end
      end
      B_READ: bst_nxt = B_PUSH;
      B_PUSH: begin
        if (o_push) begin
          if (is_last) begin
            bst_nxt = B_IDLE;
          end else begin
            k_nxt   = k_r + 5'd1;
            bst_nxt = B_READ;
          end
        end
      end
      default: bst_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r    <= B_IDLE;
      k_r      <= '0;
      single_r <= 1'b0;
    end else begin
      bst_r    <= bst_nxt;
      k_r      <= k_nxt;
      single_r <= single_nxt;
    end
    job_r <= job_nxt;
  end

  // output result queue
  assign out_empty = (ocnt_r == '0);
  assign o_pop     = out_pop && !out_empty;
  assign out_res   = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (o_push) oq_r[owp_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (o_push) owp_r <= owp_r + 1'b1;
      if (o_pop)  orp_r <= orp_r + 1'b1;
      ocnt_r <= ocnt_r + (QAW+1)'(o_push) - (QAW+1)'(o_pop);
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= (QAW+1)'(sumd_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_read_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    (bst_r == B_READ) |-> (job_r.kind == sumd_pkg::ST_GOOD && !single_r))
    else $error("store read for a job without channels");

  a_read_then_push: assert property (@(posedge clk) disable iff (!rst_n)
    (bst_r == B_READ) |=> (bst_r == B_PUSH && $stable(k_r)))
    else $error("channel index moved between store read and transfer");

endmodule

// ===== rtl/sumd_sumh_frame_decoder_unit.sv =====
// Top level of the SUMD/SUMH frame decoder: parser, job queue and emitter.
// Depends on sumd_pkg, sumd_front, sumd_jobq and sumd_back.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------------
//   in_      | input     | in_push / in_full   | in_rx_byte
//   out_     | output    | out_pop / out_empty | status, channel fields, counts, last
//   cfg_     | input     | cfg_valid/cfg_ready | cfg_max_channels
//
// The parser takes one byte per cycle while the job queue has room; the emitter takes
// each job in its idle state and moves it on from a push state before it takes the
// next, so sustained input is paced by the emitter. Any byte other than the end of a
// good frame yields one result. A good frame holds the emitter to take the job, then
// for each reported channel a store read and a transfer into the result queue.
// While a good frame is still being emitted, bytes arriving in the unsynced state stall.
// Reset is synchronous; the payload store has per-byte valid bits, so no clearing pass.
module sumd_sumh_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_rx_byte,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [4:0]  out_channel_index,
  output logic [12:0] out_channel_value,
  output logic [5:0]  out_chan_total,
  output logic        out_failsafe,
  output logic [7:0]  out_frame_count,
  output logic [6:0]  out_signal_strength,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_max_channels
);

  sumd_pkg::job_t       jq_wdata, jq_rdata;
  logic                 jq_push, jq_full, jq_pop, jq_empty;
  sumd_pkg::store_wr_t  st_wr;
  sumd_pkg::back_stat_t bk_stat;
  sumd_pkg::result_t    res;

  assign cfg_ready = 1'b1;

  sumd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_rx_byte       (in_rx_byte),
    .in_full          (in_full),
    .cfg_valid        (cfg_valid),
    .cfg_max_channels (cfg_max_channels),
    .jq_full          (jq_full),
    .jq_push          (jq_push),
    .jq_data          (jq_wdata),
    .st_wr            (st_wr),
    .bk_stat          (bk_stat)
  );

  sumd_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .wdata (jq_wdata),
    .full  (jq_full),
    .pop   (jq_pop),
    .rdata (jq_rdata),
    .empty (jq_empty)
  );

  sumd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_wr     (st_wr),
    .jq_empty  (jq_empty),
    .jq_data   (jq_rdata),
    .jq_pop    (jq_pop),
    .bk_stat   (bk_stat),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_status          = res.status;
  assign out_channel_index   = res.idx;
  assign out_channel_value   = res.val;
  assign out_chan_total      = res.cnt;
  assign out_failsafe        = res.fs;
  assign out_frame_count     = res.fc;
  assign out_signal_strength = res.ss;
  assign out_last            = res.last;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for sumd_sumh_frame_decoder_unit: drives received bytes,
// predicts every result from its own frame decoder and checks each transfer.
// Depends on sumd_pkg and the RTL of the decoder.
module testbench;

  localparam int RAND_ITEMS  = 200;
  localparam int PHASES      = 8;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 80;

  typedef enum logic [2:0] {
    PS_HUNT, PS_ID, PS_LEN, PS_PAYLOAD, PS_CHK_HI, PS_CHK_END, PS_SKIP, PS_TELEM
  } parse_t;

  // how a scripted byte is formed: literal, literal folded into the frame check,
  // or taken from the check accumulated since the last start of frame
  typedef enum logic [2:0] {TK_DATA, TK_PAD, TK_CRC_HI, TK_CRC_LO, TK_SUM_BAD} tok_t;

  typedef struct packed {
    tok_t       tok;
    logic [7:0] val;
    logic       sof;
    logic       typed;
    logic [1:0] st;
    logic [7:0] fc;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  logic [7:0]  in_rx_byte;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_status;
  logic [4:0]  out_channel_index;
  logic [12:0] out_channel_value;
  logic [5:0]  out_chan_total;
  logic        out_failsafe;
  logic [7:0]  out_frame_count;
  logic [6:0]  out_signal_strength;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_max_channels;

  // typed expectation travelling alongside the byte on the input channel
  logic        hint_on;
  logic [1:0]  hint_st;
  logic [7:0]  hint_fc;

  // decoder state as seen by the bench
  parse_t      dec_state   = PS_HUNT;
  logic        sumd_mode   = 1'b1;
  logic [15:0] run_crc     = '0;
  logic [7:0]  run_sum     = '0;
  logic [6:0]  byte_idx    = '0;
  logic [5:0]  frame_len   = '0;
  logic [7:0]  frame_id    = '0;
  logic [7:0]  chk_hi      = '0;
  logic [7:0]  good_frames = '0;
  logic [5:0]  limit_reg   = 6'd32;
  logic [7:0]  payload [64];

  sumd_pkg::result_t pending_results [$];
  int          errors     = 0;
  int          items_sent = 0;
  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;
  bit          tx_gappy   = 1'b1;

  row_t script [28] = '{
    '{TK_PAD,  8'h00, 1'b0, 1'b1, sumd_pkg::ST_DROP, 8'd0},
    '{TK_PAD,  8'hFF, 1'b0, 1'b1, sumd_pkg::ST_DROP, 8'd0},
    '{TK_PAD,  8'hA8, 1'b0, 1'b1, sumd_pkg::ST_PROG, 8'd0},
    '{TK_PAD,  8'h55, 1'b0, 1'b1, sumd_pkg::ST_PROG, 8'd0},   // bad status id
    '{TK_PAD,  8'hA8, 1'b0, 1'b1, sumd_pkg::ST_PROG, 8'd0},
    '{TK_PAD,  8'h01, 1'b0, 1'b1, sumd_pkg::ST_PROG, 8'd0},
    '{TK_PAD,  8'h21, 1'b0, 1'b1, sumd_pkg::ST_PROG, 8'd0},   // count above the channel limit
    '{TK_PAD,  8'h81, 1'b0, 1'b1, sumd_pkg::ST_DROP, 8'd0},   // not re-read as a header
    '{TK_DATA, 8'hA8, 1'b1, 1'b1, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'h81, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'h02, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'hFF, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'hFF, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'hA8, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},   // header value as payload
    '{TK_DATA, 8'h00, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_CRC_HI, 8'h00, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_CRC_LO, 8'h00, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'hA8, 1'b1, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'h00, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'h02, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'h12, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'h34, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'h56, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_DATA, 8'h78, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_PAD,  8'h00, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_PAD,  8'h00, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_PAD,  8'h00, 1'b0, 1'b0, sumd_pkg::ST_PROG, 8'd0},
    '{TK_SUM_BAD, 8'h00, 1'b0, 1'b1, sumd_pkg::ST_BAD, 8'd1}
  };

  sumd_sumh_frame_decoder_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_rx_byte          (in_rx_byte),
    .in_full             (in_full),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_status          (out_status),
    .out_channel_index   (out_channel_index),
    .out_channel_value   (out_channel_value),
    .out_chan_total      (out_chan_total),
    .out_failsafe        (out_failsafe),
    .out_frame_count     (out_frame_count),
    .out_signal_strength (out_signal_strength),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_channels    (cfg_max_channels)
  );

  always #4 clk = ~clk;

  // bitwise CRC-16, poly 0x1021, MSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ 16'h1021;
    end
    return c;
  endfunction

  task automatic fold_check(input logic [7:0] b);
    if (sumd_mode) run_crc = crc16_update(run_crc, b);
    else run_sum = run_sum + b;
  endtask

  // advances the bench's decoder by one byte and queues the results it causes
  task automatic decode_byte(input logic [7:0] b);
    sumd_pkg::result_t r;
    logic        ok;
    logic        burst;
    logic [5:0]  lim;
    logic [5:0]  nch;
    logic [15:0] w;
    int          src;
    r       = '0;
    r.status = sumd_pkg::ST_PROG;
    r.last  = 1'b1;
    burst   = 1'b0;
    case (dec_state)
      PS_HUNT: begin
        if (b != sumd_pkg::HDR_BYTE) begin
          r.status = sumd_pkg::ST_DROP;
        end else begin
          sumd_mode = 1'b1;
          byte_idx  = '0;
          foreach (payload[i]) payload[i] = '0;
          run_crc   = crc16_update(16'h0000, b);
          run_sum   = b;
          dec_state = PS_ID;
        end
      end
      PS_ID: begin
        if (b == sumd_pkg::ID_NORMAL || b == sumd_pkg::ID_FAILSAFE ||
            b == sumd_pkg::ID_ALT) begin
          frame_id = b;
          if (b == sumd_pkg::ID_ALT) sumd_mode = 1'b0;
          fold_check(b);
          dec_state = PS_LEN;
        end else begin
          dec_state = PS_HUNT;
        end
      end
      PS_LEN: begin
        if (b >= 8'd2 && b <= sumd_pkg::MAX_CHANNELS) begin
          frame_len = b[5:0];
          fold_check(b);
          byte_idx  = 7'd1;
          dec_state = PS_PAYLOAD;
        end else begin
          dec_state = PS_HUNT;
        end
      end
      PS_PAYLOAD: begin
        if (byte_idx >= 7'd1 && byte_idx <= 7'd64) payload[byte_idx - 7'd1] = b;
        fold_check(b);
        byte_idx = byte_idx + 7'd1;
        if (byte_idx > {frame_len, 1'b0}) dec_state = PS_CHK_HI;
      end
      PS_CHK_HI: begin
        chk_hi    = b;
        dec_state = sumd_mode ? PS_CHK_END : PS_SKIP;
      end
      PS_SKIP:  dec_state = PS_TELEM;
      PS_TELEM: dec_state = PS_CHK_END;
      PS_CHK_END: begin
        dec_state = PS_HUNT;
        ok = sumd_mode ? (run_crc == {chk_hi, b}) : (run_sum == b);
        if (!ok) begin
          r.status = sumd_pkg::ST_BAD;
        end else begin
          good_frames = good_frames + 8'd1;
          lim = (limit_reg > sumd_pkg::MAX_CHANNELS) ? 6'(sumd_pkg::MAX_CHANNELS) : limit_reg;
          nch = (frame_len > lim) ? lim : frame_len;
          r.status = sumd_pkg::ST_GOOD;
          r.fs     = (frame_id == sumd_pkg::ID_FAILSAFE);
          r.ss     = sumd_pkg::SIG_FULL;
          if (nch != 0) begin
            burst = 1'b1;
            for (int k = 0; k < nch; k++) begin
              // first four outputs take source channels 1, 2, 0, 3
              src = (k == 0) ? 1 : (k == 1) ? 2 : (k == 2) ? 0 : k;
              w = {payload[2 * src], payload[2 * src + 1]};
              r.idx  = 5'(k);
              r.val  = w[15:3];
              r.cnt  = nch;
              r.fc   = good_frames;
              r.last = (k == nch - 1);
              pending_results.push_back(r);
            end
          end
        end
      end
      default: dec_state = PS_HUNT;
    endcase
    if (!burst) begin
      r.fc = good_frames;
      pending_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result;
    sumd_pkg::result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result transfer with nothing expected, actual status %0d",
               $time, out_status);
      errors++;
    end else begin
      want = pending_results.pop_front();
      check_field("status", want.status, out_status);
      check_field("channel_index", want.idx, out_channel_index);
      check_field("channel_value", want.val, out_channel_value);
      check_field("chan_total", want.cnt, out_chan_total);
      check_field("failsafe", want.fs, out_failsafe);
      check_field("frame_count", want.fc, out_frame_count);
      check_field("signal_strength", want.ss, out_signal_strength);
      check_field("last", want.last, out_last);
    end
  endtask

  // every transfer on the three channels is observed here
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) limit_reg = cfg_max_channels;
      if (in_push && !in_full) begin
        decode_byte(in_rx_byte);
        if (hint_on) begin
          pending_results[pending_results.size() - 1] =
            '{status: hint_st, fc: hint_fc, last: 1'b1, default: '0};
        end
      end
      if (out_pop && !out_empty) check_result();
    end
  end

  task automatic push_item(input logic [7:0] b, input logic typed, input logic [1:0] st,
                           input logic [7:0] fc);
    in_push    <= 1'b1;
    in_rx_byte <= b;
    hint_on    <= typed;
    hint_st    <= st;
    hint_fc    <= fc;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    if (items_sent > $size(script) + RAND_ITEMS - 50) calm = 1'b1;
    if (!calm && tx_gappy && $urandom_range(0, 4) == 0) begin
      in_push    <= 1'b0;
      in_rx_byte <= 8'($urandom);
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(b, 1'b0, sumd_pkg::ST_PROG, 8'd0);
  endtask

  task automatic wait_quiet;
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [5:0] v);
    cfg_valid        <= 1'b1;
    cfg_max_channels <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // whole frame with random content; cut >= 0 sends only that many bytes
  task automatic send_frame(input int len, input logic good, input logic [7:0] id,
                            input int cut);
    logic [7:0]  frame_q [$];
    logic [15:0] crc;
    logic [7:0]  sum;
    logic [7:0]  v;
    frame_q = {sumd_pkg::HDR_BYTE, id, 8'(len)};
    crc = '0;
    sum = '0;
    foreach (frame_q[i]) begin
      crc = crc16_update(crc, frame_q[i]);
      sum = sum + frame_q[i];
    end
    for (int i = 0; i < 2 * len; i++) begin
      case ($urandom_range(0, 9))
        0:       v = 8'h00;
        1:       v = 8'hFF;
        default: v = 8'($urandom);
      endcase
      frame_q.push_back(v);
      crc = crc16_update(crc, v);
      sum = sum + v;
    end
    if (id != sumd_pkg::ID_ALT) begin
      if (!good) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      frame_q.push_back(crc[15:8]);
      frame_q.push_back(crc[7:0]);
    end else begin
      repeat (3) frame_q.push_back(8'($urandom));
      if (!good) sum = sum ^ 8'($urandom_range(1, 255));
      frame_q.push_back(sum);
    end
    foreach (frame_q[i]) if (cut < 0 || i < cut) push_byte(frame_q[i]);
  endtask

  task automatic gen_sequence;
    int         pick;
    int         len;
    logic [7:0] id;
    logic [7:0] v;
    pick     = $urandom_range(0, 99);
    tx_gappy = ($urandom_range(0, 2) != 0);
    case ($urandom_range(0, 2))
      0:       id = sumd_pkg::ID_NORMAL;
      1:       id = sumd_pkg::ID_FAILSAFE;
      default: id = sumd_pkg::ID_ALT;
    endcase
    // mostly short frames, a few at full size
    case ($urandom_range(0, 19))
      0, 1:    len = sumd_pkg::MAX_CHANNELS;
      2:       len = $urandom_range(7, sumd_pkg::MAX_CHANNELS - 1);
      default: len = $urandom_range(2, 6);
    endcase
    if (pick < 72) begin
      send_frame(len, $urandom_range(0, 6) != 0, id, -1);
    end else if (pick < 82) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
    end else if (pick < 92) begin
      push_byte(sumd_pkg::HDR_BYTE);
      if ($urandom_range(0, 1) == 0) begin
        v = 8'($urandom);
        while (v == sumd_pkg::ID_NORMAL || v == sumd_pkg::ID_FAILSAFE ||
               v == sumd_pkg::ID_ALT) v = 8'($urandom);
        push_byte(v);
      end else begin
        push_byte(id);
        case ($urandom_range(0, 2))
          0:       push_byte(8'd0);
          1:       push_byte(8'd1);
          default: push_byte(8'($urandom_range(sumd_pkg::MAX_CHANNELS + 1, 255)));
        endcase
      end
    end else begin
      send_frame(len, 1'b1, id, $urandom_range(1, 3 + 2 * len));
    end
  endtask

  // result side: random stalls, open stretches, and one long hold on request
  initial begin
    out_pop = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_pop <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [15:0] trk_crc;
    logic [7:0]  trk_sum;
    logic [7:0]  b;
    logic [5:0]  plan [PHASES];
    int          quota;
    in_push          = 1'b0;
    in_rx_byte       = '0;
    cfg_valid        = 1'b0;
    cfg_max_channels = '0;
    hint_on          = 1'b0;
    hint_st          = sumd_pkg::ST_PROG;
    hint_fc          = '0;
    rst_n            = 1'b0;
    foreach (payload[i]) payload[i] = '0;
    trk_crc = '0;
    trk_sum = '0;
    plan    = '{6'd0, 6'd63, 6'd32, 6'd3, 6'd1, 6'd0, 6'd33, 6'd4};
    plan[5] = 6'($urandom_range(0, 63));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].sof) begin
        trk_crc = '0;
        trk_sum = '0;
      end
      case (script[i].tok)
        TK_DATA: begin
          b       = script[i].val;
          trk_crc = crc16_update(trk_crc, b);
          trk_sum = trk_sum + b;
        end
        TK_CRC_HI:  b = trk_crc[15:8];
        TK_CRC_LO:  b = trk_crc[7:0];
        TK_SUM_BAD: b = trk_sum + 8'd1;
        default:    b = script[i].val;
      endcase
      push_item(b, script[i].typed, script[i].st, script[i].fc);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      write_limit(plan[p]);
      if (p == 2) begin
        // result side holds off while a full-size frame keeps coming
        hold_req = 1'b1;
        tx_gappy = 1'b0;
        send_frame(sumd_pkg::MAX_CHANNELS, 1'b1, sumd_pkg::ID_NORMAL, -1);
      end
      quota = items_sent + RAND_ITEMS / PHASES;
      while (items_sent < quota) gen_sequence();
    end

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sumd_sumh_frame_decoder_unit");
    end else begin
      $display("FAIL sumd_sumh_frame_decoder_unit");
    end
    $finish;
  end

  initial begin
    #(8 * 2000000);
    $display("FAIL sumd_sumh_frame_decoder_unit");
    $finish;
  end

endmodule
